FILE: design/sdspi_pkg.sv
package sdspi_pkg;

   localparam int BLOCK_BYTES   = 512;
   localparam int POWERUP_BYTES = 10;

   // request opcodes
   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_PAY   = 3'd3;
   localparam logic [2:0] OP_MISO  = 3'd4;
   localparam logic [2:0] OP_TICK  = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_INIT_TO  = 2'd0;
   localparam logic [1:0] CSR_READ_TO  = 2'd1;
   localparam logic [1:0] CSR_WRITE_TO = 2'd2;

   // sequencer phases
   localparam logic [5:0] PH_IDLE   = 6'd0;
   localparam logic [5:0] PH_PWRUP  = 6'd1;
   localparam logic [5:0] PH_CBUSY  = 6'd2;
   localparam logic [5:0] PH_CFRAME = 6'd3;
   localparam logic [5:0] PH_CPOLL  = 6'd4;
   localparam logic [5:0] PH_R7     = 6'd5;
   localparam logic [5:0] PH_OCR    = 6'd6;
   localparam logic [5:0] PH_RTOKEN = 6'd7;
   localparam logic [5:0] PH_RDATA  = 6'd8;
   localparam logic [5:0] PH_WTOKEN = 6'd9;
   localparam logic [5:0] PH_WNEED  = 6'd10;
   localparam logic [5:0] PH_WDATA  = 6'd11;
   localparam logic [5:0] PH_WCRC1  = 6'd12;
   localparam logic [5:0] PH_WCRC2  = 6'd13;
   localparam logic [5:0] PH_WRESP  = 6'd14;
   localparam logic [5:0] PH_WBUSY  = 6'd15;
   localparam logic [5:0] PH_WR2    = 6'd16;
   localparam logic [5:0] RET_CMD0  = 6'd20;
   localparam logic [5:0] RET_CMD8  = 6'd21;
   localparam logic [5:0] RET_A55   = 6'd22;
   localparam logic [5:0] RET_A41   = 6'd23;
   localparam logic [5:0] RET_CMD58 = 6'd24;
   localparam logic [5:0] RET_CMD17 = 6'd25;
   localparam logic [5:0] RET_CMD24 = 6'd26;
   localparam logic [5:0] RET_CMD13 = 6'd27;

   // card kinds
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_SD1     = 2'd1;
   localparam logic [1:0] KIND_SD2     = 2'd2;
   localparam logic [1:0] KIND_SDHC    = 2'd3;

   // status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_CMD0      = 4'd1;
   localparam logic [3:0] ST_CMD8      = 4'd2;
   localparam logic [3:0] ST_ACMD41    = 4'd3;
   localparam logic [3:0] ST_CMD58     = 4'd4;
   localparam logic [3:0] ST_CMD17     = 4'd5;
   localparam logic [3:0] ST_RD_TO     = 4'd6;
   localparam logic [3:0] ST_RD_TOKEN  = 4'd7;
   localparam logic [3:0] ST_BLOCK0    = 4'd8;
   localparam logic [3:0] ST_CMD24     = 4'd9;
   localparam logic [3:0] ST_REJECT    = 4'd10;
   localparam logic [3:0] ST_WR_TO     = 4'd11;
   localparam logic [3:0] ST_PROG      = 4'd12;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] block_number;
      logic [7:0]  payload_byte;
      logic [7:0]  miso_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       need_payload;
      logic       done_res;
      logic [3:0] status;
      logic [1:0] card_kind;
   } rsp_type;

   typedef struct packed {
      logic [15:0] init_to;
      logic [15:0] read_to;
      logic [15:0] write_to;
   } cfg_type;

endpackage

FILE: design/sdspi_csr.sv
module sdspi_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output sdspi_pkg::cfg_type   cfg
);

   sdspi_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sdspi_pkg::CSR_INIT_TO:  cfg_in.init_to  = csr_data;
            sdspi_pkg::CSR_READ_TO:  cfg_in.read_to  = csr_data;
            sdspi_pkg::CSR_WRITE_TO: cfg_in.write_to = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{init_to: 16'd2000, read_to: 16'd300, write_to: 16'd600};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/sdspi_seq.sv
module sdspi_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  sdspi_pkg::req_type   req,
   input  sdspi_pkg::cfg_type   cfg,
   output logic                 res_valid,
   output sdspi_pkg::rsp_type   res
);

   logic [5:0]  phase_ff, phase_in, ret_ff, ret_in;
   logic [1:0]  kind_ff, kind_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [7:0]  poll_ff, poll_in;
   logic [15:0] ielap_ff, ielap_in, welap_ff, welap_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [31:0] carg_ff, carg_in;
   logic [7:0]  lresp_ff, lresp_in;

   logic [7:0]  m, r;
   logic [9:0]  bcnt_inc;
   logic [31:0] addr;
   logic [2:0]  fsel;
   logic [7:0]  fbyte;

   // outcome of one item
   logic       emit;
   logic       o_txv, o_cs, o_rv, o_np, o_dn;
   logic [7:0] o_tx, o_rb;
   logic [3:0] o_st;
   logic       go_cmd;
   logic [5:0] c_idx, c_ret;
   logic [31:0] c_arg;

   assign m = req.miso_byte;
   assign bcnt_inc = bcnt_ff + 10'd1;
   assign addr = (kind_ff != sdspi_pkg::KIND_SDHC) ? {req.block_number[22:0], 9'd0}
                                                   : req.block_number;

   // command frame byte selected by position
   always_comb begin
      case (fsel)
         3'd0: fbyte = {2'b01, cidx_ff};
         3'd1: fbyte = carg_ff[31:24];
         3'd2: fbyte = carg_ff[23:16];
         3'd3: fbyte = carg_ff[15:8];
         3'd4: fbyte = carg_ff[7:0];
         default: fbyte = (cidx_ff == 6'd0) ? 8'h95 : (cidx_ff == 6'd8) ? 8'h87 : 8'hFF;
      endcase
   end

   // sequencer decision
   always_comb begin
      phase_in = phase_ff; ret_in = ret_ff; kind_in = kind_ff; bcnt_in = bcnt_ff;
      poll_in = poll_ff; ielap_in = ielap_ff; welap_in = welap_ff;
      cidx_in = cidx_ff; carg_in = carg_ff; lresp_in = lresp_ff;
      emit = 1'b0; o_txv = 1'b0; o_tx = 8'h00; o_cs = 1'b0; o_rv = 1'b0; o_rb = 8'h00;
      o_np = 1'b0; o_dn = 1'b0; o_st = sdspi_pkg::ST_OK;
      go_cmd = 1'b0; c_idx = 6'd0; c_arg = 32'd0; c_ret = sdspi_pkg::RET_CMD0;
      fsel = 3'd0;
      r = m;
      if (in_valid) begin
         case (req.opcode)
            sdspi_pkg::OP_INIT: begin
               if (phase_ff == sdspi_pkg::PH_IDLE) begin
                  kind_in = sdspi_pkg::KIND_UNKNOWN; ielap_in = 16'd0; bcnt_in = 10'd0;
                  phase_in = sdspi_pkg::PH_PWRUP;
                  emit = 1'b1; o_txv = 1'b1; o_tx = 8'hFF;
               end
            end
            sdspi_pkg::OP_READ: begin
               if (phase_ff == sdspi_pkg::PH_IDLE) begin
                  go_cmd = 1'b1; c_idx = 6'd17; c_arg = addr; c_ret = sdspi_pkg::RET_CMD17;
               end
            end
            sdspi_pkg::OP_WRITE: begin
               if (phase_ff == sdspi_pkg::PH_IDLE) begin
                  if (req.block_number == 32'd0) begin
                     emit = 1'b1; o_dn = 1'b1; o_st = sdspi_pkg::ST_BLOCK0;
                  end else begin
                     go_cmd = 1'b1; c_idx = 6'd24; c_arg = addr; c_ret = sdspi_pkg::RET_CMD24;
                  end
               end
            end
            sdspi_pkg::OP_PAY: begin
               if (phase_ff == sdspi_pkg::PH_WNEED) begin
                  phase_in = sdspi_pkg::PH_WDATA;
                  emit = 1'b1; o_txv = 1'b1; o_cs = 1'b1; o_tx = req.payload_byte;
               end
            end
            sdspi_pkg::OP_TICK: begin
               if (phase_ff != sdspi_pkg::PH_IDLE) begin
                  if (ielap_ff != 16'hFFFF) ielap_in = ielap_ff + 16'd1;
                  if (welap_ff != 16'hFFFF) welap_in = welap_ff + 16'd1;
               end
            end
            sdspi_pkg::OP_MISO: begin
               if (phase_ff != sdspi_pkg::PH_IDLE && phase_ff != sdspi_pkg::PH_WNEED) begin
                  emit = 1'b1; o_txv = 1'b1; o_cs = 1'b1; o_tx = 8'hFF;
                  case (phase_ff)
                     sdspi_pkg::PH_PWRUP: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc < 10'(sdspi_pkg::POWERUP_BYTES)) o_cs = 1'b0;
                        else begin
                           go_cmd = 1'b1; c_idx = 6'd0; c_ret = sdspi_pkg::RET_CMD0;
                        end
                     end
                     sdspi_pkg::PH_CBUSY: begin
                        if (m == 8'hFF || welap_ff >= cfg.read_to) begin
                           bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_CFRAME;
                           fsel = 3'd0; o_tx = fbyte;
                        end
                     end
                     sdspi_pkg::PH_CFRAME: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc < 10'd6) begin
                           fsel = bcnt_inc[2:0]; o_tx = fbyte;
                        end else begin
                           poll_in = 8'd0; phase_in = sdspi_pkg::PH_CPOLL;
                        end
                     end
                     sdspi_pkg::PH_CPOLL: begin
                        if (m[7] && poll_ff != 8'hFF) poll_in = poll_ff + 8'd1;
                        else begin
                           lresp_in = m;
                           case (ret_ff)
                              sdspi_pkg::RET_CMD0: begin
                                 if (r == 8'h01) begin
                                    go_cmd = 1'b1; c_idx = 6'd8; c_arg = 32'h1AA;
                                    c_ret = sdspi_pkg::RET_CMD8;
                                 end else if (ielap_ff > cfg.init_to) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_CMD0;
                                 end else begin
                                    go_cmd = 1'b1; c_idx = 6'd0; c_ret = sdspi_pkg::RET_CMD0;
                                 end
                              end
                              sdspi_pkg::RET_CMD8: begin
                                 if (r[2]) begin
                                    kind_in = sdspi_pkg::KIND_SD1;
                                    go_cmd = 1'b1; c_idx = 6'd55; c_ret = sdspi_pkg::RET_A55;
                                 end else begin
                                    bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_R7;
                                 end
                              end
                              sdspi_pkg::RET_A55: begin
                                 go_cmd = 1'b1; c_idx = 6'd41; c_ret = sdspi_pkg::RET_A41;
                                 c_arg = (kind_ff == sdspi_pkg::KIND_SD2) ? 32'h4000_0000 : 32'd0;
                              end
                              sdspi_pkg::RET_A41: begin
                                 if (r == 8'd0) begin
                                    if (kind_ff == sdspi_pkg::KIND_SD2) begin
                                       go_cmd = 1'b1; c_idx = 6'd58;
                                       c_ret = sdspi_pkg::RET_CMD58;
                                    end else o_dn = 1'b1;
                                 end else if (ielap_ff > cfg.init_to) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_ACMD41;
                                 end else begin
                                    go_cmd = 1'b1; c_idx = 6'd55; c_ret = sdspi_pkg::RET_A55;
                                 end
                              end
                              sdspi_pkg::RET_CMD58: begin
                                 if (r != 8'd0) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_CMD58;
                                 end else begin
                                    bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_OCR;
                                 end
                              end
                              sdspi_pkg::RET_CMD17: begin
                                 if (r != 8'd0) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_CMD17;
                                 end else begin
                                    welap_in = 16'd0; phase_in = sdspi_pkg::PH_RTOKEN;
                                 end
                              end
                              sdspi_pkg::RET_CMD24: begin
                                 if (r != 8'd0) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_CMD24;
                                 end else begin
                                    phase_in = sdspi_pkg::PH_WTOKEN; o_tx = 8'hFE;
                                 end
                              end
                              sdspi_pkg::RET_CMD13: begin
                                 if (r != 8'd0) begin
                                    o_dn = 1'b1; o_st = sdspi_pkg::ST_PROG;
                                 end else phase_in = sdspi_pkg::PH_WR2;
                              end
                              default: begin
                                 phase_in = sdspi_pkg::PH_IDLE; emit = 1'b0;
                              end
                           endcase
                        end
                     end
                     sdspi_pkg::PH_R7: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc >= 10'd4) begin
                           if (m != 8'hAA) begin
                              o_dn = 1'b1; o_st = sdspi_pkg::ST_CMD8;
                           end else begin
                              kind_in = sdspi_pkg::KIND_SD2;
                              go_cmd = 1'b1; c_idx = 6'd55; c_ret = sdspi_pkg::RET_A55;
                           end
                        end
                     end
                     sdspi_pkg::PH_OCR: begin
                        if (bcnt_ff == 10'd0 && m[7:6] == 2'b11) kind_in = sdspi_pkg::KIND_SDHC;
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc >= 10'd4) o_dn = 1'b1;
                     end
                     sdspi_pkg::PH_RTOKEN: begin
                        if (m == 8'hFF) begin
                           if (welap_ff > cfg.read_to) begin
                              o_dn = 1'b1; o_st = sdspi_pkg::ST_RD_TO;
                           end
                        end else if (m != 8'hFE) begin
                           o_dn = 1'b1; o_st = sdspi_pkg::ST_RD_TOKEN;
                        end else begin
                           bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_RDATA;
                        end
                     end
                     sdspi_pkg::PH_RDATA: begin
                        bcnt_in = bcnt_inc;
                        o_rv = 1'b1; o_rb = m;
                        if (bcnt_inc >= 10'(sdspi_pkg::BLOCK_BYTES)) o_dn = 1'b1;
                     end
                     sdspi_pkg::PH_WTOKEN: begin
                        bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_WNEED;
                        o_txv = 1'b0; o_np = 1'b1;
                     end
                     sdspi_pkg::PH_WDATA: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc < 10'(sdspi_pkg::BLOCK_BYTES)) begin
                           phase_in = sdspi_pkg::PH_WNEED; o_txv = 1'b0; o_np = 1'b1;
                        end else phase_in = sdspi_pkg::PH_WCRC1;
                     end
                     sdspi_pkg::PH_WCRC1: phase_in = sdspi_pkg::PH_WCRC2;
                     sdspi_pkg::PH_WCRC2: phase_in = sdspi_pkg::PH_WRESP;
                     sdspi_pkg::PH_WRESP: begin
                        if (m[4:0] != 5'h05) begin
                           o_dn = 1'b1; o_st = sdspi_pkg::ST_REJECT;
                        end else begin
                           welap_in = 16'd0; phase_in = sdspi_pkg::PH_WBUSY;
                        end
                     end
                     sdspi_pkg::PH_WBUSY: begin
                        if (m == 8'hFF) begin
                           go_cmd = 1'b1; c_idx = 6'd13; c_ret = sdspi_pkg::RET_CMD13;
                        end else if (welap_ff >= cfg.write_to) begin
                           o_dn = 1'b1; o_st = sdspi_pkg::ST_WR_TO;
                        end
                     end
                     sdspi_pkg::PH_WR2: begin
                        o_dn = 1'b1;
                        o_st = (m != 8'd0) ? sdspi_pkg::ST_PROG : sdspi_pkg::ST_OK;
                     end
                     default: emit = 1'b0;
                  endcase
               end
            end
            default: ;
         endcase
         // command launch: busy wait before the frame
         if (go_cmd) begin
            cidx_in = c_idx; carg_in = c_arg; ret_in = c_ret; welap_in = 16'd0;
            phase_in = sdspi_pkg::PH_CBUSY;
            emit = 1'b1; o_txv = 1'b1; o_tx = 8'hFF; o_cs = 1'b1;
         end
         // done item deselects the card
         if (o_dn) begin
            phase_in = sdspi_pkg::PH_IDLE; o_txv = 1'b0; o_cs = 1'b0; emit = 1'b1;
         end
      end
   end

   assign res_valid = emit;
   assign res = '{tx_valid: o_txv, tx_byte: o_txv ? o_tx : 8'h00, chip_select: o_cs,
                  read_valid: o_rv, read_byte: o_rv ? o_rb : 8'h00, need_payload: o_np,
                  done_res: o_dn, status: o_dn ? o_st : 4'd0, card_kind: kind_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::PH_IDLE; ret_ff <= sdspi_pkg::PH_IDLE;
         kind_ff <= sdspi_pkg::KIND_UNKNOWN; bcnt_ff <= '0; poll_ff <= '0;
         ielap_ff <= '0; welap_ff <= '0; cidx_ff <= '0; carg_ff <= '0; lresp_ff <= '0;
      end else begin
         phase_ff <= phase_in; ret_ff <= ret_in; kind_ff <= kind_in; bcnt_ff <= bcnt_in;
         poll_ff <= poll_in; ielap_ff <= ielap_in; welap_ff <= welap_in;
         cidx_ff <= cidx_in; carg_ff <= carg_in; lresp_ff <= lresp_in;
      end
   end

endmodule

FILE: design/sd_card_spi_host_sequencer_unit.sv
// path: input register, combinational sequencer, result register
// throughput: one item per cycle while the result side does not stall
// results wait in the result register; the input stage takes a new item while it
// is empty or the next stage can move, so a stalled output backs up to the input
// reset: synchronous, active high; phase idle, kind unknown, timeouts 2000/300/600 ticks
module sd_card_spi_host_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_block_number,
   input  logic [7:0]  req_payload_byte,
   input  logic [7:0]  req_miso_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_chip_select,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_need_payload,
   output logic        rsp_done_res,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_card_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   sdspi_pkg::cfg_type cfg;
   sdspi_pkg::req_type req_ff, req_in;
   sdspi_pkg::rsp_type rsp_ff, res;
   logic in_vld_ff, in_vld_in, out_vld_ff, out_vld_in, res_valid, adv;

   sdspi_csr u_csr (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   // input register moves when the result register can take its item
   assign adv = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !adv;
   assign req_in = '{opcode: req_opcode, block_number: req_block_number,
                     payload_byte: req_payload_byte, miso_byte: req_miso_byte};
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   sdspi_seq u_seq (
      .clock(clock), .reset(reset), .in_valid(in_vld_ff && adv), .req(req_ff),
      .cfg(cfg), .res_valid(res_valid), .res(res)
   );

   assign out_vld_in = adv ? (in_vld_ff && res_valid) : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0; out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in; out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) req_ff <= req_in;
      if (adv) rsp_ff <= res;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_tx_valid     = rsp_ff.tx_valid;
   assign rsp_tx_byte      = rsp_ff.tx_byte;
   assign rsp_chip_select  = rsp_ff.chip_select;
   assign rsp_read_valid   = rsp_ff.read_valid;
   assign rsp_read_byte    = rsp_ff.read_byte;
   assign rsp_need_payload = rsp_ff.need_payload;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_status       = rsp_ff.status;
   assign rsp_card_kind    = rsp_ff.card_kind;

endmodule

FILE: design/sdspi_checker.sv
module sdspi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_chip_select,
   input logic       rsp_done_res,
   input logic [3:0] rsp_status
);

   // a stalled result item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("stalled item changed");

   // a finished request deselects and sends nothing
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_tx_valid && !rsp_chip_select)
      else $error("done item still transfers");

   // status carries a code only on a done item
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == 4'd0)
      else $error("status without done");

   // no input stall unless the output is full and stalled
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

endmodule

bind sd_card_spi_host_sequencer_unit sdspi_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tx_valid(rsp_tx_valid),
   .rsp_tx_byte(rsp_tx_byte), .rsp_chip_select(rsp_chip_select),
   .rsp_done_res(rsp_done_res), .rsp_status(rsp_status)
);
